/* sv/ecu_pkg.sv */
package ecu_pkg;

  localparam int REG_COUNT_DEFAULT   = 64;
  localparam int STORE_DEPTH_DEFAULT = 64;

  typedef enum logic [3:0] {
    OP_ADD  = 4'd0,
    OP_SUB  = 4'd1,
    OP_MUL  = 4'd2,
    OP_MOVI = 4'd3,
    OP_BEQZ = 4'd4,
    OP_ANDI = 4'd5,
    OP_EOR  = 4'd6,
    OP_BR   = 4'd7,
    OP_SAL  = 4'd8,
    OP_SAR  = 4'd9,
    OP_LDR  = 4'd10,
    OP_STR  = 4'd11
  } opcode_t;

  typedef struct packed {
    logic [15:0] instruction;
    logic [15:0] pc_in;
  } instr_t;

  typedef struct packed {
    logic [15:0] pc_out;
    logic        carry;
    logic        overflow;
    logic        negative;
    logic        sign_flag;
    logic        zero_flag;
    logic        reg_written;
    logic [5:0]  write_index;
    logic [7:0]  write_value;
  } result_t;

  typedef struct packed {
    logic zero;
    logic sign;
    logic neg;
    logic ovf;
    logic carry;
  } flags_t;

  typedef struct packed {
    logic [15:0] pc_out;
    flags_t      flags;
    logic        wr;
    logic [7:0]  value;
  } alu_out_t;

endpackage

/* sv/ecu_alu.sv */
module ecu_alu (
  input  logic [3:0]        op,
  input  logic [5:0]        r1,
  input  logic [5:0]        imm,
  input  logic [7:0]        a,
  input  logic [7:0]        b,
  input  logic [7:0]        mem_data,
  input  logic [15:0]       pc,
  input  ecu_pkg::flags_t   flags,
  output ecu_pkg::alu_out_t alu
);
  import ecu_pkg::*;

  logic [8:0] sum;
  logic [8:0] diff;
  logic [7:0] prod;
  logic [7:0] imm8;
  logic [7:0] value;
  logic       c;
  logic       v;
  logic       upd;
  logic       wr;
  logic [15:0] pc_next;

  assign sum  = {1'b0, a} + {1'b0, b};
  assign diff = {1'b0, a} - {1'b0, b};
  assign prod = a * b;
  assign imm8 = {2'b00, imm};

  always_comb begin
    value   = '0;
    c       = 1'b0;
    v       = 1'b0;
    upd     = 1'b0;
    wr      = 1'b0;
    pc_next = pc;
    unique case (op)
      OP_ADD: begin
        value = sum[7:0];
        c     = sum[8];
        v     = (a[7] == b[7]) && (sum[7] != a[7]);
        upd   = 1'b1;
        wr    = 1'b1;
      end
      OP_SUB: begin
        value = diff[7:0];
        c     = diff[8];
        v     = (a[7] != b[7]) && (diff[7] != a[7]);
        upd   = 1'b1;
        wr    = 1'b1;
      end
      OP_MUL: begin
        value = prod;
        upd   = 1'b1;
        wr    = 1'b1;
      end
      OP_MOVI: begin
        value = imm8;
        upd   = 1'b1;
        wr    = 1'b1;
      end
      OP_BEQZ: begin
        if (a == 8'd0) begin
          pc_next = pc + 16'(imm) + 16'd1;
        end
      end
      OP_ANDI: begin
        value = a & imm8;
        upd   = 1'b1;
        wr    = 1'b1;
      end
      OP_EOR: begin
        value = a ^ imm8;
        upd   = 1'b1;
        wr    = 1'b1;
      end
      OP_BR: begin
        pc_next = {a, imm8};
      end
      OP_SAL: begin
        value = (imm[5:3] != 3'd0) ? 8'd0 : (a << imm[2:0]);
        upd   = 1'b1;
        wr    = 1'b1;
      end
      OP_SAR: begin
        value = (imm[5:3] != 3'd0) ? 8'd0 : (a >> imm[2:0]);
        upd   = 1'b1;
        wr    = 1'b1;
      end
      OP_LDR: begin
        // load into register 0 is dropped
        if (r1 != 6'd0) begin
          value = mem_data;
          wr    = 1'b1;
        end
      end
      OP_STR: begin
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    alu.pc_out = pc_next;
    alu.wr     = wr;
    alu.value  = value;
    if (upd) begin
      alu.flags.carry = c;
      alu.flags.ovf   = v;
      alu.flags.neg   = value[7];
      alu.flags.sign  = value[7] ^ v;
      alu.flags.zero  = (value == 8'd0);
    end else begin
      alu.flags = flags;
    end
  end

endmodule

/* sv/eight_bit_cpu_execute_unit.sv */
// Channel  Valid        Stall        Payload
// instr    instr_valid  instr_stall  instr (instruction, pc_in)
// res      res_valid    res_stall    res   (pc_out, flags, register write)
//
// One instruction per cycle while instr_stall is low. A transfer on instr reads the
// register file and data store (synchronous reads); the execute stage then executes,
// writes back and loads the output register when res can advance. Back-to-back
// hazards on a register or store byte are forwarded. After reset the store and the
// registers below STORE_DEPTH are zeroed, one entry a cycle, instr_stall held high.
// A stalled result holds the execute stage, which then stalls instr.
module eight_bit_cpu_execute_unit #(
  parameter int REG_COUNT   = ecu_pkg::REG_COUNT_DEFAULT,
  parameter int STORE_DEPTH = ecu_pkg::STORE_DEPTH_DEFAULT
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             instr_valid,
  output logic             instr_stall,
  input  ecu_pkg::instr_t  instr,
  output logic             res_valid,
  input  logic             res_stall,
  output ecu_pkg::result_t res
);
  import ecu_pkg::*;

  localparam int RA_W = $clog2(REG_COUNT);
  localparam int SA_W = $clog2(STORE_DEPTH);

  logic [7:0] rf_mem [REG_COUNT];
  logic [7:0] ds_mem [STORE_DEPTH];

  logic            clearing;
  logic [SA_W-1:0] clr_addr;

  logic accept;
  logic s1_adv;

  logic [5:0] in_r1;
  logic [5:0] in_imm;

  logic        s1_valid;
  logic [15:0] s1_instr;
  logic [15:0] s1_pc;
  logic        s1_a_ok;
  logic        s1_b_ok;
  logic        fwd_a;
  logic        fwd_b;
  logic        fwd_m;
  logic [7:0]  fwd_rf_data;
  logic [7:0]  fwd_m_data;
  logic [7:0]  rf_qa;
  logic [7:0]  rf_qb;
  logic [7:0]  ds_q;

  logic [3:0]  s1_op;
  logic [5:0]  s1_r1;
  logic [5:0]  s1_imm;
  logic [7:0]  a_val;
  logic [7:0]  b_val;
  logic [7:0]  m_val;
  flags_t      flags;
  alu_out_t    alu;

  logic        wr_ok;
  logic        rf_we;
  logic        ds_we;
  logic        rf_mem_we;
  logic [RA_W-1:0] rf_mem_addr;
  logic [7:0]  rf_mem_data;
  logic        ds_mem_we;
  logic [SA_W-1:0] ds_mem_addr;
  logic [7:0]  ds_mem_data;

  assign in_r1  = instr.instruction[11:6];
  assign in_imm = instr.instruction[5:0];

  assign s1_adv      = !res_valid || !res_stall;
  assign instr_stall = clearing || (s1_valid && !s1_adv);
  assign accept      = instr_valid && !instr_stall;

  assign s1_op  = s1_instr[15:12];
  assign s1_r1  = s1_instr[11:6];
  assign s1_imm = s1_instr[5:0];

  assign a_val = fwd_a ? fwd_rf_data : (s1_a_ok ? rf_qa : 8'd0);
  assign b_val = fwd_b ? fwd_rf_data : (s1_b_ok ? rf_qb : 8'd0);
  assign m_val = fwd_m ? fwd_m_data : ds_q;

  ecu_alu u_alu (
    .op       (s1_op),
    .r1       (s1_r1),
    .imm      (s1_imm),
    .a        (a_val),
    .b        (b_val),
    .mem_data (m_val),
    .pc       (s1_pc),
    .flags    (flags),
    .alu      (alu)
  );

  assign wr_ok = alu.wr && s1_a_ok;
  assign rf_we = s1_valid && s1_adv && wr_ok;
  assign ds_we = s1_valid && s1_adv && (s1_op == OP_STR);

  always_comb begin
    if (clearing) begin
      rf_mem_we   = ({1'b0, clr_addr} < (SA_W+1)'(REG_COUNT));
      rf_mem_addr = clr_addr[RA_W-1:0];
      rf_mem_data = 8'd0;
      ds_mem_we   = 1'b1;
      ds_mem_addr = clr_addr;
      ds_mem_data = 8'd0;
    end else begin
      rf_mem_we   = rf_we;
      rf_mem_addr = s1_r1[RA_W-1:0];
      rf_mem_data = alu.value;
      ds_mem_we   = ds_we;
      ds_mem_addr = SA_W'(s1_imm);
      ds_mem_data = a_val;
    end
  end

  always_ff @(posedge clk) begin
    if (rf_mem_we) begin
      rf_mem[rf_mem_addr] <= rf_mem_data;
    end
    if (accept) begin
      rf_qa <= rf_mem[in_r1[RA_W-1:0]];
      rf_qb <= rf_mem[in_imm[RA_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (ds_mem_we) begin
      ds_mem[ds_mem_addr] <= ds_mem_data;
    end
    if (accept) begin
      ds_q <= ds_mem[SA_W'(in_imm)];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      if (clr_addr == SA_W'(STORE_DEPTH - 1)) begin
        clearing <= 1'b0;
      end
      clr_addr <= clr_addr + SA_W'(1);
    end
  end

  // execute stage; forward flags catch a write landing on the same edge as the read
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_instr    <= instr.instruction;
      s1_pc       <= instr.pc_in;
      s1_a_ok     <= ({1'b0, in_r1} < 7'(REG_COUNT));
      s1_b_ok     <= ({1'b0, in_imm} < 7'(REG_COUNT));
      fwd_a       <= rf_we && (s1_r1 == in_r1);
      fwd_b       <= rf_we && (s1_r1 == in_imm);
      fwd_m       <= ds_we && (s1_imm == in_imm);
      fwd_rf_data <= alu.value;
      fwd_m_data  <= a_val;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      flags <= '0;
    end else if (s1_valid && s1_adv) begin
      flags <= alu.flags;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (s1_valid && s1_adv) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid && s1_adv) begin
      res.pc_out      <= alu.pc_out;
      res.carry       <= alu.flags.carry;
      res.overflow    <= alu.flags.ovf;
      res.negative    <= alu.flags.neg;
      res.sign_flag   <= alu.flags.sign;
      res.zero_flag   <= alu.flags.zero;
      res.reg_written <= wr_ok;
      res.write_index <= wr_ok ? s1_r1 : 6'd0;
      res.write_value <= wr_ok ? alu.value : 8'd0;
    end
  end

endmodule
